FILE: rtl/bdq_pkg.sv
// Shared types, request and status codes for the bounded deque.
`default_nettype none
package bdq_pkg;

  // Default store depth
  localparam int DEPTH_DEF = 16;

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Value reported by a pop or delete on an empty queue
  localparam logic signed [VAL_W-1:0] EMPTY_VAL = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_W-1:0]        count;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/bounded_deque_with_value_delete.sv
// Bounded deque of signed 32-bit values with delete-by-value, top level.
//
// Requests arrive on the in_ channel (valid/ready); each one returns exactly
// one result beat on the out_ channel: status, removed value, entry count.
// Entries live in a RAM with registered read data, used as a ring buffer.
// Work per request, from the accepting edge until in_ready can rise again:
//   push or unused code: result registered at once (a push writes the RAM)
//   pop front or back:   one RAM read, then the result
//   pop or delete on an empty queue, push into a full queue: result at once
//   delete by value: the search reads one entry per cycle from the front;
//   on a match before the last entry, the tail then moves up one entry per
//   cycle, each step one RAM write paired with a read of the next entry, if any.
// Results sit in an output register; while idle, a new request is accepted
// in the cycle the held result is taken, or whenever it is empty. A stalled
// receiver therefore holds the block after at most one waiting result.
// Synchronous reset (rst_n low) empties the queue and drops any pending
// result; the RAM is not cleared, since only occupied entries are read.
`default_nettype none
module bounded_deque_with_value_delete #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bdq_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bdq_pkg::out_t      out_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int VW     = bdq_pkg::VAL_W;
  localparam int OutCnt = bdq_pkg::CNT_W;

  // Controller state codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POP    = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [VW-1:0] val_r, val_nxt;
  bdq_pkg::out_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  logic          accept;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] off_p1;
  logic [CW:0]   off_p2;
  logic [AW-1:0] front_dec;

  // Ring position of the entry at a given offset from the front
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  bdq_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign off_p1    = off_r + CW'(1);
  assign off_p2    = (CW + 1)'(off_r) + (CW + 1)'(2);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : (front_r - AW'(1));

  // Sequence each request through the store and build its result
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    off_nxt       = off_r;
    val_nxt       = val_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    wr_data       = in_data.value;
    rd_en         = 1'b0;
    rd_addr       = front_r;

    // Drop the held beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = bdq_pkg::ST_OK;
          out_nxt.removed_value = '0;
          out_nxt.count         = OutCnt'(count_r);
          case (in_data.func)
            bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
              if (count_r == CW'(DEPTH)) begin
                out_nxt.status = bdq_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                if (in_data.func == bdq_pkg::FN_PUSH_FRONT) begin
                  wr_addr   = front_dec;
                  front_nxt = front_dec;
                end else begin
                  wr_addr = wrap(front_r, count_r);
                end
                count_nxt     = count_inc;
                out_nxt.count = OutCnt'(count_inc);
              end
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
              if (count_r == '0) begin
                out_nxt.status        = bdq_pkg::ST_EMPTY;
                out_nxt.removed_value = bdq_pkg::EMPTY_VAL;
              end else begin
                rd_en = 1'b1;
                if (in_data.func == bdq_pkg::FN_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = wrap(front_r, CW'(1));
                end else begin
                  rd_addr = wrap(front_r, count_dec);
                end
                count_nxt     = count_dec;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            bdq_pkg::FN_DELETE: begin
              if (count_r == '0) begin
                out_nxt.status        = bdq_pkg::ST_EMPTY;
                out_nxt.removed_value = bdq_pkg::EMPTY_VAL;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = front_r;
                off_nxt       = '0;
                val_nxt       = in_data.value;
                out_valid_nxt = 1'b0;
                state_nxt     = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Return the popped entry
      S_POP: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = bdq_pkg::ST_OK;
        out_nxt.removed_value = rd_data;
        out_nxt.count         = OutCnt'(count_r);
        state_nxt             = S_IDLE;
      end

      // Compare entry at off_r, prefetch the next one
      S_SEARCH: begin
        if (off_p1 < count_r) begin
          rd_en   = 1'b1;
          rd_addr = wrap(front_r, off_p1);
        end
        if (rd_data == val_r) begin
          if (off_p1 < count_r) begin
            state_nxt = S_SHIFT;
          end else begin
            count_nxt             = count_dec;
            out_valid_nxt         = 1'b1;
            out_nxt.status        = bdq_pkg::ST_OK;
            out_nxt.removed_value = val_r;
            out_nxt.count         = OutCnt'(count_dec);
            state_nxt             = S_IDLE;
          end
        end else if (off_p1 < count_r) begin
          off_nxt = off_p1;
        end else begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = bdq_pkg::ST_NOTFOUND;
          out_nxt.removed_value = '0;
          out_nxt.count         = OutCnt'(count_r);
          state_nxt             = S_IDLE;
        end
      end

      // Move entry off_r+1 up to off_r, prefetch off_r+2
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = wrap(front_r, off_r);
        wr_data = rd_data;
        off_nxt = off_p1;
        if (off_p2 < (CW + 1)'(count_r)) begin
          rd_en   = 1'b1;
          rd_addr = wrap(front_r, off_p2[CW-1:0]);
        end else begin
          count_nxt             = count_dec;
          out_valid_nxt         = 1'b1;
          out_nxt.status        = bdq_pkg::ST_OK;
          out_nxt.removed_value = val_r;
          out_nxt.count         = OutCnt'(count_dec);
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("request taken while busy");

  a_busy_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result beat held during a multi-cycle request");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.func == bdq_pkg::FN_PUSH_BACK) && (count_r != CW'(DEPTH)))
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not add an entry");
`endif

endmodule
`default_nettype wire

FILE: rtl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
